### design/method_descriptor_parser_core_defines.svh
// ----------------------------------------------------------------------------
// method_descriptor_parser_core_defines
// Assertion macros for the method descriptor parser core.
// ----------------------------------------------------------------------------
`ifndef METHOD_DESCRIPTOR_PARSER_CORE_DEFINES_SVH
`define METHOD_DESCRIPTOR_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define MDP_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mdp assertion failed");

// antecedent implies consequent in the next cycle
`define MDP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mdp assertion failed");

`else

`define MDP_ASSERT(label, cond)
`define MDP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/mdp_pkg.sv
// ----------------------------------------------------------------------------
// mdp_pkg
// Types, codes and helpers shared by the method descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mdp_pkg;

	localparam int MAX_DESC_LEN_DEF   = 65536;
	localparam int MAX_ARRAY_DIMS_DEF = 255;

	// descriptor characters
	localparam logic [15:0] CH_LPAREN = 16'h0028;
	localparam logic [15:0] CH_RPAREN = 16'h0029;
	localparam logic [15:0] CH_SEMI   = 16'h003B;
	localparam logic [15:0] CH_LBRACK = 16'h005B;
	localparam logic [15:0] CH_L      = 16'h004C;
	localparam logic [15:0] CH_V      = 16'h0056;
	localparam logic [15:0] CH_Z      = 16'h005A;
	localparam logic [15:0] CH_C      = 16'h0043;
	localparam logic [15:0] CH_F      = 16'h0046;
	localparam logic [15:0] CH_D      = 16'h0044;
	localparam logic [15:0] CH_B      = 16'h0042;
	localparam logic [15:0] CH_S      = 16'h0053;
	localparam logic [15:0] CH_I      = 16'h0049;
	localparam logic [15:0] CH_J      = 16'h004A;

	// type kinds
	localparam logic [3:0] K_BOOL   = 4'd0;
	localparam logic [3:0] K_CHAR   = 4'd1;
	localparam logic [3:0] K_FLOAT  = 4'd2;
	localparam logic [3:0] K_DOUBLE = 4'd3;
	localparam logic [3:0] K_BYTE   = 4'd4;
	localparam logic [3:0] K_SHORT  = 4'd5;
	localparam logic [3:0] K_INT    = 4'd6;
	localparam logic [3:0] K_LONG   = 4'd7;
	localparam logic [3:0] K_ARRAY  = 4'd8;
	localparam logic [3:0] K_REF    = 4'd9;
	localparam logic [3:0] K_VOID   = 4'd10;

	// result events
	localparam logic [1:0] EV_PARAM = 2'd0;
	localparam logic [1:0] EV_FINAL = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
	localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
	localparam logic [2:0] ERR_EARLY_END = 3'd3;
	localparam logic [2:0] ERR_NO_SEMI   = 3'd4;
	localparam logic [2:0] ERR_TRAILING  = 3'd5;
	localparam logic [2:0] ERR_DIMS      = 3'd6;

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_PARAM,
		PH_PARR,
		PH_PCLS,
		PH_RET,
		PH_RARR,
		PH_RCLS,
		PH_DISCARD
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  dim_depth;
		logic [15:0] type_start;
		logic [15:0] position;
		logic [16:0] slots;
		logic [15:0] param_counter;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_OPEN,
		dim_depth:     8'd0,
		type_start:    16'd0,
		position:      16'd0,
		slots:         17'd0,
		param_counter: 16'd0
	};

	typedef struct packed {
		logic [1:0]  event_res;
		logic [3:0]  type_kind;
		logic [3:0]  element_kind;
		logic [7:0]  array_dims;
		logic [15:0] start_pos;
		logic [15:0] type_length;
		logic [15:0] param_index;
		logic [16:0] slot_total;
		logic [2:0]  error_code;
		logic        end_of_run;
	} res_t;

	// {is_primitive, kind}
	function automatic logic [4:0] prim_code(input logic [15:0] c);
		logic [4:0] r;
		case (c)
			CH_Z:    r = {1'b1, K_BOOL};
			CH_C:    r = {1'b1, K_CHAR};
			CH_F:    r = {1'b1, K_FLOAT};
			CH_D:    r = {1'b1, K_DOUBLE};
			CH_B:    r = {1'b1, K_BYTE};
			CH_S:    r = {1'b1, K_SHORT};
			CH_I:    r = {1'b1, K_INT};
			CH_J:    r = {1'b1, K_LONG};
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### design/mdp_step.sv
// ----------------------------------------------------------------------------
// mdp_step
// Next-state and result logic for one descriptor code unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_step #(
	parameter int MAX_DESC_LEN   = mdp_pkg::MAX_DESC_LEN_DEF,
	parameter int MAX_ARRAY_DIMS = mdp_pkg::MAX_ARRAY_DIMS_DEF
) (
	input  mdp_pkg::state_t st,
	input  logic [15:0]     ch,
	input  logic            last,
	output mdp_pkg::state_t nxt,
	output logic            emit,
	output mdp_pkg::res_t   res
);
	import mdp_pkg::*;

	state_t      w;
	logic [15:0] pos;
	logic [15:0] pos_inc;
	logic        is_ret;
	logic        done;
	logic        final_hit;
	logic [2:0]  err;
	logic [3:0]  elem;
	logic [3:0]  kind;
	logic [4:0]  pr;

	always_comb begin
		w         = st;
		pos       = st.position;
		pos_inc   = st.position + 16'd1;
		is_ret    = (st.phase == PH_RET) || (st.phase == PH_RARR) || (st.phase == PH_RCLS);
		pr        = prim_code(ch);
		done      = 1'b0;
		final_hit = 1'b0;
		err       = ERR_NONE;
		elem      = K_BOOL;
		kind      = K_BOOL;
		emit      = 1'b0;
		res       = '0;

		if (st.phase == PH_DISCARD) begin
			if (last) begin
				w = STATE_RESET;
			end else begin
				w.position = pos_inc;
			end
		end else begin
			case (st.phase)
				PH_OPEN: begin
					if (ch == CH_LPAREN) begin
						w.phase = PH_PARAM;
					end else begin
						err = ERR_NO_OPEN;
					end
				end
				PH_PARAM, PH_RET: begin
					w.dim_depth  = 8'd0;
					w.type_start = pos;
					if (!is_ret && ch == CH_RPAREN) begin
						w.phase = PH_RET;
					end else if (ch == CH_LBRACK) begin
						w.dim_depth = 8'd1;
						w.phase     = is_ret ? PH_RARR : PH_PARR;
					end else if (ch == CH_L) begin
						w.phase = is_ret ? PH_RCLS : PH_PCLS;
					end else if (pr[4]) begin
						done = 1'b1;
						elem = pr[3:0];
					end else if (is_ret && ch == CH_V) begin
						done = 1'b1;
						elem = K_VOID;
					end else begin
						err = ERR_BAD_CHAR;
					end
				end
				PH_PARR, PH_RARR: begin
					if (ch == CH_LBRACK) begin
						if (st.dim_depth >= 8'(MAX_ARRAY_DIMS)) begin
							err = ERR_DIMS;
						end else begin
							w.dim_depth = st.dim_depth + 8'd1;
						end
					end else if (ch == CH_L) begin
						w.phase = is_ret ? PH_RCLS : PH_PCLS;
					end else if (pr[4]) begin
						done = 1'b1;
						elem = pr[3:0];
					end else begin
						err = ERR_BAD_CHAR;
					end
				end
				default: begin
					// class name runs to the first semicolon; "L;" is empty
					if (ch == CH_SEMI) begin
						if (pos == 16'(st.type_start + 16'(st.dim_depth) + 16'd1)) begin
							err = ERR_BAD_CHAR;
						end else begin
							done = 1'b1;
							elem = K_REF;
						end
					end
				end
			endcase

			kind = (w.dim_depth != 8'd0) ? K_ARRAY : elem;

			if (err == ERR_NONE && done) begin
				if (!is_ret) begin
					if (w.dim_depth == 8'd0 && (elem == K_DOUBLE || elem == K_LONG)) begin
						w.slots = w.slots + 17'd2;
					end else begin
						w.slots = w.slots + 17'd1;
					end
					emit             = 1'b1;
					res.event_res    = EV_PARAM;
					res.type_kind    = kind;
					res.element_kind = elem;
					res.array_dims   = w.dim_depth;
					res.start_pos    = w.type_start;
					res.type_length  = pos - w.type_start + 16'd1;
					res.param_index  = w.param_counter;
					res.slot_total   = w.slots;
					w.param_counter  = w.param_counter + 16'd1;
					w.phase          = PH_PARAM;
					w.dim_depth      = 8'd0;
				end else if (last) begin
					final_hit        = 1'b1;
					emit             = 1'b1;
					res.event_res    = EV_FINAL;
					res.type_kind    = kind;
					res.element_kind = elem;
					res.array_dims   = w.dim_depth;
					res.start_pos    = w.type_start;
					res.type_length  = pos - w.type_start + 16'd1;
					res.param_index  = w.param_counter;
					res.slot_total   = w.slots;
					res.end_of_run   = 1'b1;
					w                = STATE_RESET;
				end else begin
					err = ERR_TRAILING;
				end
			end

			if (!final_hit) begin
				if (err == ERR_NONE && last) begin
					err = (w.phase == PH_PCLS || w.phase == PH_RCLS) ? ERR_NO_SEMI
						: ERR_EARLY_END;
				end
				if (err == ERR_NONE && !last && (17'(pos) + 17'd1) >= 17'(MAX_DESC_LEN)) begin
					err = ERR_TRAILING;
				end

				if (err != ERR_NONE) begin
					// replaces a parameter beat, but its counts stay taken
					emit            = 1'b1;
					res             = '0;
					res.event_res   = EV_ERROR;
					res.start_pos   = pos;
					res.param_index = w.param_counter;
					res.slot_total  = w.slots;
					res.error_code  = err;
					res.end_of_run  = 1'b1;
					if (last) begin
						w = STATE_RESET;
					end else begin
						w.phase    = PH_DISCARD;
						w.position = pos_inc;
					end
				end else begin
					w.position = pos_inc;
				end
			end
		end

		nxt = w;
	end

endmodule

`default_nettype wire

### design/method_descriptor_parser_core.sv
// ----------------------------------------------------------------------------
// method_descriptor_parser_core
// Streaming parser for method type descriptors, one code unit per beat.
// ----------------------------------------------------------------------------
// Takes one code unit per clock unless stalled and gives at most one result
// beat per unit. The unit is captured in an input register, the parse state
// update and result decode run in one pass of next-state logic, and the
// result is held in an output register. The state feedback through that
// single pass sets the rate of one unit per cycle, unless a result meets a
// held output; a unit with no result moves on while the output waits.
`default_nettype none

`include "method_descriptor_parser_core_defines.svh"

module method_descriptor_parser_core #(
	parameter int MAX_DESC_LEN   = mdp_pkg::MAX_DESC_LEN_DEF,
	parameter int MAX_ARRAY_DIMS = mdp_pkg::MAX_ARRAY_DIMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [3:0]  type_kind,
	output logic [3:0]  element_kind,
	output logic [7:0]  array_dims,
	output logic [15:0] start_pos,
	output logic [15:0] type_length,
	output logic [15:0] param_index,
	output logic [16:0] slot_total,
	output logic [2:0]  error_code,
	output logic        end_of_run
);
	import mdp_pkg::*;

	logic        valid_s1;
	logic [15:0] ch_s1;
	logic        last_s1;
	state_t      state_q;
	state_t      state_nxt;
	logic        emit;
	res_t        res;
	res_t        res_q;
	logic        out_valid_q;
	logic        out_free;
	logic        advance;

	mdp_step #(
		.MAX_DESC_LEN   (MAX_DESC_LEN),
		.MAX_ARRAY_DIMS (MAX_ARRAY_DIMS)
	) u_step (
		.st   (state_q),
		.ch   (ch_s1),
		.last (last_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= advance && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = res_q.event_res;
	assign type_kind    = res_q.type_kind;
	assign element_kind = res_q.element_kind;
	assign array_dims   = res_q.array_dims;
	assign start_pos    = res_q.start_pos;
	assign type_length  = res_q.type_length;
	assign param_index  = res_q.param_index;
	assign slot_total   = res_q.slot_total;
	assign error_code   = res_q.error_code;
	assign end_of_run   = res_q.end_of_run;

	`MDP_ASSERT(a_err_beat_fields, !out_valid || event_res != EV_ERROR || (error_code != ERR_NONE && type_kind == K_BOOL && type_length == 16'd0 && end_of_run))
	`MDP_ASSERT(a_ok_beat_no_code, !out_valid || event_res == EV_ERROR || error_code == ERR_NONE)
	`MDP_ASSERT(a_param_not_end, !out_valid || event_res != EV_PARAM || !end_of_run)
	`MDP_ASSERT_NEXT(a_last_resets, advance && last_s1, state_q.phase == PH_OPEN && state_q.position == 16'd0 && state_q.param_counter == 16'd0)

endmodule

`default_nettype wire
